// ----- sv/mtt_pkg.sv -----
package mtt_pkg;

	localparam int MaxTimers = 16;
	localparam int SlotW     = $clog2(MaxTimers);
	localparam int TotalW    = $clog2(MaxTimers + 1);
	localparam int ResCap    = 16;
	localparam int ResW      = $clog2(ResCap + 1);

	typedef enum logic [2:0] {
		CMD_ADD         = 3'd0,
		CMD_REMOVE      = 3'd1,
		CMD_MODIFY      = 3'd2,
		CMD_ENABLE      = 3'd3,
		CMD_READ_FLAG   = 3'd4,
		CMD_RESET_COUNT = 3'd5,
		CMD_TICK        = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_FOUND   = 3'd1,
		ST_FULL        = 3'd2,
		ST_DUPLICATE   = 3'd3,
		ST_NOT_EXPIRED = 3'd4,
		ST_EXPIRED     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ENABLE,
		OP_READ_FLAG,
		OP_RESET_COUNT
	} step_op_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  timer_id;
		logic [31:0] period;
		logic        oneshot_mode;
		logic [7:0]  enable_value;
		logic        notify_enable;
		logic [31:0] count_load;
		logic        flag_load;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic        is_event;
		logic [7:0]  event_id;
		logic        last;
	} response_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] period;
		logic [31:0] count;
		logic        mode;
		logic [7:0]  enable;
		logic        notify;
		logic        flag;
	} slot_t;

	typedef struct packed {
		slot_t       slot;
		logic        fire;
		status_t     status;
	} step_out_t;

endpackage

// ----- sv/multi_timer_table.sv -----
// Timer table with up to 16 timers keyed by an 8-bit id. A command is taken when start is
// high and busy is low. Add, remove and modify finish in the cycle of acceptance and answer
// on the next cycle, leaving busy low. Enable, read flag and reset count go through the slot
// memory read and an apply state when the id is found. A tick walks the live timers in
// insertion order, one slot memory access per cycle through a shared count/compare unit, and
// closes in a tick end state; on an empty table it answers like add. Each result is shown
// for exactly one cycle with response_valid high; the receiver cannot stall, and last marks
// the final result of a command. Command code seven is taken and does nothing.
module multi_timer_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mtt_pkg::request_t   request,
	output logic                busy,
	output logic                response_valid,
	output mtt_pkg::response_t  response
);
	import mtt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_TICK,
		S_TICK_END
	} state_t;

	state_t             state_q;
	logic [MaxTimers-1:0] slot_valid_q;
	logic [7:0]         slot_id_q [MaxTimers];
	logic [SlotW-1:0]   visit_q [MaxTimers];
	logic [TotalW-1:0]  total_q;
	logic [TotalW-1:0]  pos_q;
	logic [SlotW-1:0]   cur_q;
	step_op_t           op_q;
	logic [7:0]         en_q;
	logic [ResW-1:0]    n_q;
	logic               pend_q;
	logic [7:0]         pend_id_q;
	response_t          res_q;
	logic               res_valid_q;

	slot_t              slot_mem [MaxTimers];
	slot_t              slot_rd_q;

	logic               accept;
	logic [MaxTimers-1:0] match;
	logic [MaxTimers-1:0] vhit;
	logic [MaxTimers-1:0] seen;
	logic [SlotW-1:0]   visit_next [MaxTimers];
	logic [SlotW-1:0]   match_idx;
	logic [SlotW-1:0]   free_idx;
	logic               found;
	logic               full;
	logic               mem_we;
	logic [SlotW-1:0]   mem_waddr;
	logic [SlotW-1:0]   mem_raddr;
	slot_t              mem_wdata;
	step_op_t           step_op;
	step_out_t          step;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign found  = |match;
	assign full   = (total_q == TotalW'(MaxTimers));

	for (genvar i = 0; i < MaxTimers; i++) begin : g_slot
		assign match[i] = slot_valid_q[i] && (slot_id_q[i] == request.timer_id);
		assign vhit[i]  = (TotalW'(i) < total_q) && (visit_q[i] == match_idx);
		assign seen[i]  = |vhit[i:0];
		if (i == MaxTimers - 1) begin : g_tail
			assign visit_next[i] = visit_q[i];
		end else begin : g_body
			assign visit_next[i] = seen[i] ? visit_q[i+1] : visit_q[i];
		end
	end

	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = MaxTimers - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_idx = SlotW'(i);
			end
			if (!slot_valid_q[i]) begin
				free_idx = SlotW'(i);
			end
		end
	end

	assign step_op = (state_q == S_TICK) ? OP_TICK : op_q;

	mtt_step_unit u_step (
		.op           (step_op),
		.enable_value (en_q),
		.cur          (slot_rd_q),
		.result       (step)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = step.slot;
		mem_raddr = match_idx;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_t'(request.command) == CMD_TICK) begin
					mem_raddr = visit_q[0];
				end
				if (accept && cmd_t'(request.command) == CMD_ADD && !full && !found) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx;
					mem_wdata = '{id: request.timer_id, period: request.period, count: 32'd0,
						mode: request.oneshot_mode, enable: request.enable_value,
						notify: request.notify_enable, flag: 1'b0};
				end
				if (accept && cmd_t'(request.command) == CMD_MODIFY && found) begin
					mem_we    = 1'b1;
					mem_waddr = match_idx;
					mem_wdata = '{id: request.timer_id, period: request.period,
						count: request.count_load, mode: request.oneshot_mode,
						enable: request.enable_value, notify: request.notify_enable,
						flag: request.flag_load};
				end
			end
			S_APPLY: begin
				mem_we = 1'b1;
			end
			S_TICK: begin
				mem_we    = 1'b1;
				mem_raddr = visit_q[pos_q[SlotW-1:0]];
			end
			S_TICK_END: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		slot_rd_q <= slot_mem[mem_raddr];
	end

	function automatic response_t make_res(status_t st, logic ev, logic [7:0] id, logic lst);
		response_t r;
		r.status   = st;
		r.is_event = ev;
		r.event_id = id;
		r.last     = lst;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			for (int i = 0; i < MaxTimers; i++) begin
				slot_id_q[i] <= '0;
				visit_q[i]   <= '0;
			end
			total_q     <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			op_q        <= OP_TICK;
			en_q        <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd_t'(request.command))
							CMD_ADD: begin
								res_valid_q <= 1'b1;
								if (full) begin
									res_q <= make_res(ST_FULL, 1'b0, 8'd0, 1'b1);
								end else if (found) begin
									res_q <= make_res(ST_DUPLICATE, 1'b0, 8'd0, 1'b1);
								end else begin
									res_q                 <= make_res(ST_OK, 1'b0, 8'd0, 1'b1);
									slot_valid_q[free_idx] <= 1'b1;
									slot_id_q[free_idx]    <= request.timer_id;
									visit_q[total_q[SlotW-1:0]] <= free_idx;
									total_q               <= total_q + 1'b1;
								end
							end
							CMD_REMOVE: begin
								res_valid_q <= 1'b1;
								if (found) begin
									res_q <= make_res(ST_OK, 1'b0, 8'd0, 1'b1);
									slot_valid_q[match_idx] <= 1'b0;
									for (int i = 0; i < MaxTimers; i++) begin
										visit_q[i] <= visit_next[i];
									end
									total_q <= total_q - 1'b1;
								end else begin
									res_q <= make_res(ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
								end
							end
							CMD_MODIFY: begin
								res_valid_q <= 1'b1;
								res_q <= make_res(found ? ST_OK : ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
							end
							CMD_ENABLE, CMD_READ_FLAG, CMD_RESET_COUNT: begin
								if (found) begin
									cur_q   <= match_idx;
									en_q    <= request.enable_value;
									state_q <= S_APPLY;
									unique case (cmd_t'(request.command))
										CMD_ENABLE:    op_q <= OP_ENABLE;
										CMD_READ_FLAG: op_q <= OP_READ_FLAG;
										default:       op_q <= OP_RESET_COUNT;
									endcase
								end else begin
									res_valid_q <= 1'b1;
									res_q <= make_res(ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
								end
							end
							CMD_TICK: begin
								if (total_q == '0) begin
									res_valid_q <= 1'b1;
									res_q <= make_res(ST_OK, 1'b0, 8'd0, 1'b1);
								end else begin
									cur_q   <= visit_q[0];
									pos_q   <= TotalW'(1);
									n_q     <= '0;
									pend_q  <= 1'b0;
									state_q <= S_TICK;
								end
							end
							default: ;
						endcase
					end
				end
				S_APPLY: begin
					res_valid_q <= 1'b1;
					res_q       <= make_res(step.status, 1'b0, 8'd0, 1'b1);
					state_q     <= S_IDLE;
				end
				S_TICK: begin
					if (step.fire && slot_rd_q.notify && n_q < ResW'(ResCap)) begin
						if (pend_q) begin
							res_valid_q <= 1'b1;
							res_q       <= make_res(ST_OK, 1'b1, pend_id_q, 1'b0);
						end
						pend_q    <= 1'b1;
						pend_id_q <= slot_rd_q.id;
						n_q       <= n_q + 1'b1;
					end
					if (pos_q < total_q) begin
						cur_q <= visit_q[pos_q[SlotW-1:0]];
						pos_q <= pos_q + 1'b1;
					end else begin
						state_q <= S_TICK_END;
					end
				end
				S_TICK_END: begin
					res_valid_q <= 1'b1;
					res_q       <= pend_q ? make_res(ST_OK, 1'b1, pend_id_q, 1'b1)
						: make_res(ST_OK, 1'b0, 8'd0, 1'b1);
					state_q     <= S_IDLE;
				end
				default: ;
			endcase
		end
	end

	assign response_valid = res_valid_q;
	assign response       = res_q;

	// live slot count and visit list length agree
	a_total_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == 32'(total_q))
		else $error("timer count out of step with valid slots");

	// a tick over a nonempty table keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_t'(request.command) == CMD_TICK && total_q != '0 |=> busy)
		else $error("tick did not start a walk");

	// only a tick walk gives non-final results
	a_nonlast_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.last |-> state_q == S_TICK || state_q == S_TICK_END)
		else $error("non-final result outside a tick");

	// a tick always closes with a final result
	a_tick_closes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK_END |=> res_valid_q && res_q.last)
		else $error("tick ended without a final result");

	// event count never passes the cap
	a_event_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= ResW'(ResCap))
		else $error("event count above cap");

endmodule

// ----- sv/mtt_step_unit.sv -----
module mtt_step_unit (
	input  mtt_pkg::step_op_t  op,
	input  logic [7:0]         enable_value,
	input  mtt_pkg::slot_t     cur,
	output mtt_pkg::step_out_t result
);
	import mtt_pkg::*;

	logic [31:0] count_inc;
	logic        hit;

	always_comb begin
		count_inc = cur.count;
		if (cur.count < cur.period && cur.enable == 8'd1) begin
			count_inc = cur.count + 32'd1;
		end
		hit = (count_inc == cur.period);
	end

	always_comb begin
		result.slot   = cur;
		result.fire   = 1'b0;
		result.status = ST_OK;
		unique case (op)
			OP_TICK: begin
				result.fire       = hit;
				result.slot.count = (hit && !cur.mode) ? 32'd0 : count_inc;
				result.slot.flag  = cur.flag | hit;
			end
			OP_ENABLE: begin
				result.slot.enable = enable_value;
			end
			OP_READ_FLAG: begin
				result.slot.flag = 1'b0;
				result.status    = cur.flag ? ST_EXPIRED : ST_NOT_EXPIRED;
			end
			OP_RESET_COUNT: begin
				result.slot.count = 32'd0;
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/multi_timer_table_tb.sv -----
`timescale 1ns / 1ps

module multi_timer_table_tb;
	import mtt_pkg::*;

	localparam logic [2:0] CmdUnused = 3'd7;
	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 40;

	logic clk;
	logic arst_n;
	logic start;
	request_t request;
	logic busy;
	logic response_valid;
	response_t response;

	// expected result beats, oldest first
	response_t due_results[$];

	// shadow copy of the timer table
	bit          tm_valid[MaxTimers];
	logic [7:0]  tm_id[MaxTimers];
	logic [31:0] tm_period[MaxTimers];
	logic [31:0] tm_count[MaxTimers];
	bit          tm_oneshot[MaxTimers];
	logic [7:0]  tm_enable[MaxTimers];
	bit          tm_notify[MaxTimers];
	bit          tm_flag[MaxTimers];
	int          visit_order[$];

	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	logic [7:0] id_pool[$];

	multi_timer_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.response_valid(response_valid),
		.response(response)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("multi_timer_table test failed");
			$finish;
		end
	end

	function automatic int lookup(logic [7:0] id);
		for (int i = 0; i < MaxTimers; i++)
			if (tm_valid[i] && tm_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic request_t make_request(logic [2:0] cmd, logic [7:0] id, logic [31:0] per,
			logic md, logic [7:0] en, logic nt, logic [31:0] cl, logic fl);
		request_t r;
		r.command = cmd;
		r.timer_id = id;
		r.period = per;
		r.oneshot_mode = md;
		r.enable_value = en;
		r.notify_enable = nt;
		r.count_load = cl;
		r.flag_load = fl;
		return r;
	endfunction

	// check result beats, then predict the beats of a command taken at this edge
	always @(posedge clk) begin : scoreboard
		response_t want;
		response_t fired[$];
		int slot;
		int k;
		if (arst_n && response_valid) begin
			if (due_results.size() == 0) begin
				$error("unexpected result beat: status %0d is_event %0b event_id %0h",
					response.status, response.is_event, response.event_id);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (response.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, response.status);
					errors++;
				end
				if (response.is_event !== want.is_event) begin
					$error("is_event: expected %0b, got %0b", want.is_event, response.is_event);
					errors++;
				end
				if (response.event_id !== want.event_id) begin
					$error("event_id: expected %0h, got %0h", want.event_id, response.event_id);
					errors++;
				end
				if (response.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, response.last);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			want.status = ST_OK;
			want.is_event = 1'b0;
			want.event_id = 8'h00;
			want.last = 1'b1;
			if (request.command == CMD_TICK) begin
				fired = {};
				foreach (visit_order[i]) begin
					k = visit_order[i];
					if (tm_count[k] < tm_period[k] && tm_enable[k] == 8'd1)
						tm_count[k]++;
					if (tm_count[k] == tm_period[k]) begin
						if (!tm_oneshot[k])
							tm_count[k] = '0;
						tm_flag[k] = 1'b1;
						if (tm_notify[k] && fired.size() < ResCap) begin
							want.is_event = 1'b1;
							want.event_id = tm_id[k];
							want.last = 1'b0;
							fired.push_back(want);
						end
					end
				end
				if (fired.size() == 0) begin
					want.is_event = 1'b0;
					want.event_id = 8'h00;
					want.last = 1'b1;
					due_results.push_back(want);
				end else begin
					fired[fired.size() - 1].last = 1'b1;
					foreach (fired[i])
						due_results.push_back(fired[i]);
				end
			end else if (request.command != CmdUnused) begin
				slot = lookup(request.timer_id);
				if (request.command == CMD_ADD) begin
					if (visit_order.size() >= MaxTimers) begin
						want.status = ST_FULL;
					end else if (slot >= 0) begin
						want.status = ST_DUPLICATE;
					end else begin
						for (k = 0; k < MaxTimers && tm_valid[k]; k++)
							;
						tm_valid[k] = 1'b1;
						tm_id[k] = request.timer_id;
						tm_period[k] = request.period;
						tm_count[k] = '0;
						tm_oneshot[k] = request.oneshot_mode;
						tm_enable[k] = request.enable_value;
						tm_notify[k] = request.notify_enable;
						tm_flag[k] = 1'b0;
						visit_order.push_back(k);
					end
				end else if (slot < 0) begin
					want.status = ST_NOT_FOUND;
				end else begin
					case (request.command)
						CMD_REMOVE: begin
							tm_valid[slot] = 1'b0;
							for (k = 0; k < visit_order.size(); k++)
								if (visit_order[k] == slot)
									break;
							visit_order.delete(k);
						end
						CMD_MODIFY: begin
							tm_period[slot] = request.period;
							tm_count[slot] = request.count_load;
							tm_oneshot[slot] = request.oneshot_mode;
							tm_enable[slot] = request.enable_value;
							tm_notify[slot] = request.notify_enable;
							tm_flag[slot] = request.flag_load;
						end
						CMD_ENABLE: tm_enable[slot] = request.enable_value;
						CMD_READ_FLAG: begin
							if (tm_flag[slot]) begin
								tm_flag[slot] = 1'b0;
								want.status = ST_EXPIRED;
							end else begin
								want.status = ST_NOT_EXPIRED;
							end
						end
						default: tm_count[slot] = '0;
					endcase
				end
				due_results.push_back(want);
			end
		end
	end

	task automatic send_beat(request_t r);
		if (idle_on && $urandom_range(99) < 19) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic test_commands();
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_ADD, 8'h00, 32'd0, 1'b0, 8'd1, 1'b1, '0, 1'b0));
		send_beat(make_request(CMD_ADD, 8'h00, 32'd5, 1'b1, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0,
			32'hFFFF_FFFF, 1'b1));
		send_beat(make_request(CMD_REMOVE, 8'h55, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_MODIFY, 8'h55, 32'd1, 1'b0, 8'd1, 1'b1, 32'd1, 1'b1));
		send_beat(make_request(CMD_ENABLE, 8'h55, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_READ_FLAG, 8'h55, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_RESET_COUNT, 8'h55, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CmdUnused, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1,
			32'hFFFF_FFFF, 1'b1));
	endtask

	task automatic test_tick_rules();
		// one-shot holds at period and fires on every tick from then on
		send_beat(make_request(CMD_ADD, 8'h10, 32'd2, 1'b1, 8'd1, 1'b1, '0, 1'b0));
		repeat (3)
			send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_READ_FLAG, 8'h10, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_READ_FLAG, 8'h10, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		// count above period stops counting and firing
		send_beat(make_request(CMD_MODIFY, 8'h10, 32'd3, 1'b0, 8'd1, 1'b1, 32'hFFFF_FFFF, 1'b1));
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_READ_FLAG, 8'h10, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_RESET_COUNT, 8'h10, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		// period zero fires while disabled
		send_beat(make_request(CMD_ENABLE, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_REMOVE, 8'h00, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_REMOVE, 8'hFF, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
	endtask

	task automatic test_table_full();
		send_beat(make_request(CMD_MODIFY, 8'h10, 32'd0, 1'b0, 8'd1, 1'b1, '0, 1'b0));
		for (int i = 0; i < MaxTimers - 1; i++)
			send_beat(make_request(CMD_ADD, 8'(8'h80 + i), 32'd0, i[0], 8'd1, 1'b1, '0, 1'b0));
		send_beat(make_request(CMD_ADD, 8'h7F, 32'd1, 1'b0, 8'd1, 1'b1, '0, 1'b0));
		// every timer fires: a full burst of events
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
		// freed slot is reused but the new timer goes last in visit order
		send_beat(make_request(CMD_REMOVE, 8'h85, '0, 1'b0, 8'd1, 1'b0, '0, 1'b0));
		send_beat(make_request(CMD_ADD, 8'h01, 32'd0, 1'b0, 8'd1, 1'b1, '0, 1'b0));
		send_beat(make_request(CMD_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0, '0, 1'b0));
	endtask

	task automatic test_random();
		request_t r;
		int pick;
		id_pool = {};
		id_pool.push_back(8'h10);
		id_pool.push_back(8'h01);
		for (int i = 0; i < MaxTimers - 1; i++)
			id_pool.push_back(8'(8'h80 + i));
		repeat (7)
			id_pool.push_back(8'($urandom));
		for (int n = 0; n < 54; n++) begin
			idle_on = !(n >= 15 && n < 40);
			pick = $urandom_range(99);
			if (pick < 30)
				r.command = CMD_TICK;
			else if (pick < 45)
				r.command = CMD_ADD;
			else if (pick < 58)
				r.command = CMD_REMOVE;
			else if (pick < 70)
				r.command = CMD_MODIFY;
			else if (pick < 80)
				r.command = CMD_ENABLE;
			else if (pick < 90)
				r.command = CMD_READ_FLAG;
			else if (pick < 97)
				r.command = CMD_RESET_COUNT;
			else
				r.command = CmdUnused;
			r.timer_id = ($urandom_range(19) == 0) ? 8'($urandom)
				: id_pool[$urandom_range(id_pool.size() - 1)];
			r.period = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 6);
			r.oneshot_mode = 1'($urandom_range(1));
			r.enable_value = ($urandom_range(4) == 0) ? 8'($urandom) : 8'd1;
			r.notify_enable = ($urandom_range(3) != 0);
			r.count_load = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 7);
			r.flag_load = 1'($urandom_range(1));
			send_beat(r);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_tick_rules();
		test_table_full();
		test_random();
		@(negedge clk);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("multi_timer_table test passed");
		else
			$display("multi_timer_table test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mtt_pkg.sv
sv/mtt_step_unit.sv
sv/multi_timer_table.sv
tb/multi_timer_table_tb.sv
